>>> rtl/rrsb_pkg.sv
// Package for the range routed stack bank: operation codes, field widths,
// status codes and the controller-to-datapath command bundle. No dependencies.
package rrsb_pkg;

  localparam int VALUE_W    = 16;
  localparam int OP_W       = 2;
  localparam int USED_W     = 2;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic load;
    logic eval;
  } cmd_t;

endpackage

>>> rtl/rrsb_if.sv
// Channel interfaces: request channel (operation, item_value) and result channel.
// Depends on rrsb_pkg.
interface rrsb_req_if;
  import rrsb_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [VALUE_W-1:0] item_value;

  modport source (output valid, output operation, output item_value, input ready);
  modport sink   (input valid, input operation, input item_value, output ready);
endinterface

interface rrsb_rsp_if;
  import rrsb_pkg::*;

  logic               valid;
  logic               ready;
  logic               status;
  logic [VALUE_W-1:0] read_value;
  logic [USED_W-1:0]  stack_used;
  logic               no_room;
  logic               no_content;

  modport source (output valid, output status, output read_value, output stack_used,
                  output no_room, output no_content, input ready);
  modport sink   (input valid, input status, input read_value, input stack_used,
                  input no_room, input no_content, output ready);
endinterface

>>> rtl/rrsb_ctrl.sv
// Controller: sequences one transaction through load, evaluate and deliver.
// Depends on rrsb_pkg.
module rrsb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output rrsb_pkg::cmd_t  cmd
);
  import rrsb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/rrsb_dp.sv
// Datapath: bound registers, fill counts, stack memory, range match and
// stack selection, result registers. Depends on rrsb_pkg.
module rrsb_dp #(
  parameter int NUM_STACKS  = 4,
  parameter int STACK_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rrsb_pkg::cmd_t                  cmd,
  input  logic                            cfg_we,
  input  logic [rrsb_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [rrsb_pkg::VALUE_W-1:0]    cfg_data,
  input  logic [rrsb_pkg::OP_W-1:0]       operation,
  input  logic [rrsb_pkg::VALUE_W-1:0]    item_value,
  output logic                            status,
  output logic [rrsb_pkg::VALUE_W-1:0]    read_value,
  output logic [rrsb_pkg::USED_W-1:0]     stack_used,
  output logic                            no_room,
  output logic                            no_content
);
  import rrsb_pkg::*;

  localparam int SW        = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int PW        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW        = $clog2(STACK_DEPTH + 1);
  localparam int AW        = SW + PW;
  localparam int MEM_DEPTH = 2 ** AW;

  logic [VALUE_W-1:0] bounds [NUM_REGS];
  logic [CW-1:0]      fill [NUM_STACKS];
  logic [VALUE_W-1:0] mem [MEM_DEPTH];
  logic [VALUE_W-1:0] mem_rdata;

  logic [OP_W-1:0]    op_q;
  logic [VALUE_W-1:0] val_q;
  logic               show_rd;

  logic [NUM_STACKS-1:0] match, has_room, has_data;
  logic                  push_hit, pop_hit, nonzero;
  logic [USED_W-1:0]     push_sel, pop_sel;
  logic [PW-1:0]         push_ptr, pop_ptr;
  logic                  do_push, do_read;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= operation;
      val_q <= item_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        bounds[i] <= VALUE_W'(i);
      end
    end else if (cfg_we) begin
      bounds[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int s = 0; s < NUM_STACKS; s++) begin
      match[s]    = (val_q >= bounds[2*s]) && (val_q <= bounds[2*s+1]);
      has_room[s] = match[s] && (fill[s] < CW'(STACK_DEPTH));
      has_data[s] = match[s] && (fill[s] != '0);
    end
  end

  always_comb begin
    push_hit = 1'b0;
    push_sel = '0;
    push_ptr = '0;
    for (int s = NUM_STACKS - 1; s >= 0; s--) begin
      if (has_room[s]) begin
        push_hit = 1'b1;
        push_sel = USED_W'(s);
        push_ptr = fill[s][PW-1:0];
      end
    end
  end

  always_comb begin
    pop_hit = 1'b0;
    pop_sel = '0;
    pop_ptr = '0;
    for (int s = 0; s < NUM_STACKS; s++) begin
      if (has_data[s]) begin
        pop_hit = 1'b1;
        pop_sel = USED_W'(s);
        pop_ptr = PW'(fill[s] - CW'(1));
      end
    end
  end

  assign nonzero = (val_q != '0);
  assign do_push = nonzero && (op_q == OP_PUSH) && push_hit;
  assign do_read = nonzero && ((op_q == OP_POP) || (op_q == OP_PEEK)) && pop_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_STACKS; s++) begin
        fill[s] <= '0;
      end
    end else if (cmd.eval) begin
      for (int s = 0; s < NUM_STACKS; s++) begin
        if (do_push && (push_sel == USED_W'(s))) begin
          fill[s] <= fill[s] + CW'(1);
        end else if (do_read && (op_q == OP_POP) && (pop_sel == USED_W'(s))) begin
          fill[s] <= fill[s] - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && do_push) begin
      mem[{push_sel[SW-1:0], push_ptr}] <= val_q;
    end
    if (cmd.eval && do_read) begin
      mem_rdata <= mem[{pop_sel[SW-1:0], pop_ptr}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      show_rd    <= do_read;
      status     <= (do_push || do_read) ? STATUS_DONE : STATUS_REJECT;
      stack_used <= do_push ? push_sel : (do_read ? pop_sel : '0);
      no_room    <= ~|has_room;
      no_content <= ~|has_data;
    end
  end

  assign read_value = show_rd ? mem_rdata : '0;

endmodule

>>> rtl/range_routed_stack_bank.sv
// Range routed stack bank: a bank of bounded stacks, each taking values in its
// configured range. Each request passes through the load, evaluate and deliver
// sequence around the registered stack memory read; a new request is taken
// only after the result of the previous one has been taken.
// Reset (rst, synchronous) empties all stacks and loads bound register i with i.
module range_routed_stack_bank #(
  parameter int NUM_STACKS  = 4,
  parameter int STACK_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  rrsb_req_if.sink                        in_chan,
  rrsb_rsp_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [rrsb_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [rrsb_pkg::VALUE_W-1:0]    cfg_data
);
  import rrsb_pkg::*;

  cmd_t cmd;

  rrsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  rrsb_dp #(
    .NUM_STACKS  (NUM_STACKS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .operation  (in_chan.operation),
    .item_value (in_chan.item_value),
    .status     (out_chan.status),
    .read_value (out_chan.read_value),
    .stack_used (out_chan.stack_used),
    .no_room    (out_chan.no_room),
    .no_content (out_chan.no_content)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("request taken while a transaction is in flight");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_chan.ready && out_chan.valid))
    else $error("request side open while a result is pending");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_chan.valid && (out_chan.status == STATUS_REJECT)) |->
      ((out_chan.stack_used == '0) && (out_chan.read_value == '0)))
    else $error("rejected result carries nonzero fields");

  a_ready_after_result: assert property (@(posedge clk) disable iff (rst)
    (out_chan.valid && out_chan.ready) |=> in_chan.ready)
    else $error("request side not reopened after result taken");

endmodule
